[rtl/u8trunc_pkg.sv]
// Shared types and constants for the UTF-8 display width truncator.
package u8trunc_pkg;

  localparam int unsigned MAX_STRING_BYTES = 65535;
  localparam logic [15:0] POS_CAP =
    (MAX_STRING_BYTES < 65535) ? 16'(MAX_STRING_BYTES) : 16'hFFFF;
  localparam logic [16:0] WIDTH_CAP = 17'h1FFFF;
  localparam logic [15:0] MAX_WIDTH_RESET = 16'd80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] keep_bytes;
    logic        add_ellipsis;
    logic [16:0] total_width;
  } out_item_t;

endpackage

[rtl/utf8_display_width_truncator_core.sv]
// Top level: UTF-8 display width truncator with input and result registers.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one string byte per request,
//    in_data.is_last marks the final byte. Empty strings are not sent.
//  - Output channel (out_valid / out_stall / out_data): one result per string,
//    issued for the last byte: keep_bytes, add_ellipsis, total_width.
//  - Config channel (cfg_valid / cfg_ready / cfg_data): writes max_display_width.
//    cfg_ready is always high; write only while no string is in flight.
// Timing: a byte is registered in the input register at acceptance and is
//  processed from there; its result goes to the result register. One byte per
//  cycle is sustained unless a last byte waits on a stalled result; the decode,
//  width lookup and add sit in a single stage between the two registers.
// Stall: while out_stall holds a result, non-last bytes keep flowing; a last
//  byte waits in the input register and in_stall rises until the result drains.
// Reset: clears scan state and both registers; max_display_width returns to 80.
module utf8_display_width_truncator_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  u8trunc_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output u8trunc_pkg::out_item_t out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            cfg_data
);
  import u8trunc_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_advance;
  logic [15:0] width_limit;
  out_item_t scan_res;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!s1_item.is_last || !out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  u8trunc_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_advance),
    .item        (s1_item),
    .width_limit (width_limit),
    .res         (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_limit <= MAX_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_item.is_last) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && s1_item.is_last) begin
      out_data <= scan_res;
    end
  end

endmodule

[rtl/u8trunc_scan.sv]
// Per-string scan state: UTF-8 decode, width sum, cut search and result.
module u8trunc_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  u8trunc_pkg::in_item_t item,
  input  logic [15:0]           width_limit,
  output u8trunc_pkg::out_item_t res
);
  import u8trunc_pkg::*;

  logic [15:0] byte_position, byte_position_next;
  logic [20:0] code_point_accumulator, code_point_accumulator_next;
  logic [2:0]  bytes_remaining, bytes_remaining_next;
  logic [15:0] char_start_position, char_start_position_next;
  logic [16:0] width_sum, width_sum_next;
  logic        counting_stopped, counting_stopped_next;
  logic        cut_found, cut_found_next;
  logic [15:0] cut_position, cut_position_next;

  logic        finish;
  logic [20:0] cp;
  logic [1:0]  glyph_w;
  logic [17:0] sum_ext;
  logic [7:0]  b;

  function automatic logic [1:0] glyph_width(input logic [20:0] c);
    logic wide;
    begin
      wide = (c >= 21'h1100  && c <= 21'h115F)  || (c >= 21'h2E80  && c <= 21'h303E)  ||
             (c >= 21'h3041  && c <= 21'h33FF)  || (c >= 21'h3400  && c <= 21'h4DBF)  ||
             (c >= 21'h4E00  && c <= 21'h9FFF)  || (c >= 21'hA000  && c <= 21'hA4CF)  ||
             (c >= 21'hAC00  && c <= 21'hD7A3)  || (c >= 21'hF900  && c <= 21'hFAFF)  ||
             (c >= 21'hFE30  && c <= 21'hFE4F)  || (c >= 21'hFF00  && c <= 21'hFF60)  ||
             (c >= 21'hFFE0  && c <= 21'hFFE6)  || (c >= 21'h1F300 && c <= 21'h1F9FF) ||
             (c >= 21'h20000 && c <= 21'h2FFFD);
      if (c < 21'h20 || (c >= 21'h7F && c < 21'hA0)) glyph_width = 2'd0;
      else if (wide)                                 glyph_width = 2'd2;
      else                                           glyph_width = 2'd1;
    end
  endfunction

  assign b = item.data_byte;

  always_comb begin
    byte_position_next          = byte_position;
    code_point_accumulator_next = code_point_accumulator;
    bytes_remaining_next        = bytes_remaining;
    char_start_position_next    = char_start_position;
    width_sum_next              = width_sum;
    counting_stopped_next       = counting_stopped;
    cut_found_next              = cut_found;
    cut_position_next           = cut_position;
    finish                      = 1'b0;
    cp                          = {13'd0, b};

    if (byte_position >= POS_CAP) begin
      counting_stopped_next = 1'b1;
    end else begin
      byte_position_next = byte_position + 16'd1;
      if (!counting_stopped) begin
        if (bytes_remaining == 3'd0) begin
          char_start_position_next = byte_position;
          if (b[7] == 1'b0) begin
            finish = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            code_point_accumulator_next = {16'd0, b[4:0]};
            bytes_remaining_next        = 3'd1;
          end else if (b[7:4] == 4'b1110) begin
            code_point_accumulator_next = {17'd0, b[3:0]};
            bytes_remaining_next        = 3'd2;
          end else if (b[7:3] == 5'b11110) begin
            code_point_accumulator_next = {18'd0, b[2:0]};
            bytes_remaining_next        = 3'd3;
          end else begin
            counting_stopped_next = 1'b1;
          end
        end else begin
          code_point_accumulator_next = {code_point_accumulator[14:0], b[5:0]};
          bytes_remaining_next        = bytes_remaining - 3'd1;
          cp                          = code_point_accumulator_next;
          finish                      = (bytes_remaining == 3'd1);
        end
      end
    end

    glyph_w = glyph_width(cp);
    sum_ext = {1'b0, width_sum} + {16'd0, glyph_w};
    if (finish) begin
      if (!cut_found && sum_ext >= {2'b00, width_limit}) begin
        cut_found_next    = 1'b1;
        cut_position_next = char_start_position_next;
      end
      width_sum_next = sum_ext[17] ? WIDTH_CAP : sum_ext[16:0];
    end

    res.total_width = width_sum_next;
    if (width_limit == 16'd0) begin
      res.keep_bytes   = 16'd0;
      res.add_ellipsis = 1'b0;
    end else if (width_sum_next <= {1'b0, width_limit} || !cut_found_next) begin
      res.keep_bytes   = byte_position_next;
      res.add_ellipsis = 1'b0;
    end else begin
      res.keep_bytes   = cut_position_next;
      res.add_ellipsis = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.is_last)) begin
      byte_position          <= '0;
      code_point_accumulator <= '0;
      bytes_remaining        <= '0;
      char_start_position    <= '0;
      width_sum              <= '0;
      counting_stopped       <= 1'b0;
      cut_found              <= 1'b0;
      cut_position           <= '0;
    end else if (step) begin
      byte_position          <= byte_position_next;
      code_point_accumulator <= code_point_accumulator_next;
      bytes_remaining        <= bytes_remaining_next;
      char_start_position    <= char_start_position_next;
      width_sum              <= width_sum_next;
      counting_stopped       <= counting_stopped_next;
      cut_found              <= cut_found_next;
      cut_position           <= cut_position_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && item.is_last |=> byte_position == 16'd0 && width_sum == 17'd0 && !cut_found)
    else $error("scan state not cleared after last byte");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    bytes_remaining <= 3'd3)
    else $error("bytes_remaining out of range");

  a_cut_before_pos: assert property (@(posedge clk) disable iff (rst)
    cut_found |-> cut_position < byte_position)
    else $error("cut position beyond scanned bytes");

  a_width_monotone: assert property (@(posedge clk) disable iff (rst)
    step && !item.is_last |=> width_sum >= $past(width_sum))
    else $error("width sum decreased within a string");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    counting_stopped && step && !item.is_last |=> counting_stopped)
    else $error("counting resumed within a string");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for utf8_display_width_truncator_core: streams strings, checks each result.
module tb_top;
  import u8trunc_pkg::*;

  localparam int STALL_LIMIT = 1000;

  typedef enum int {CH_RANGE_EDGE, CH_ASCII, CH_RAW} char_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // scan state of the predictor
  logic [15:0] col_limit = MAX_WIDTH_RESET;
  logic [15:0] scan_pos = '0;
  logic [20:0] cp_acc = '0;
  logic [2:0]  cont_left = '0;
  logic [15:0] glyph_start = '0;
  logic [16:0] col_sum = '0;
  logic        scan_halted = 1'b0;
  logic        cut_seen = 1'b0;
  logic [15:0] cut_at = '0;

  out_item_t   pending_results[$];
  logic [7:0]  str_bytes[$];
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;
  bit          stall_en = 1'b1;

  utf8_display_width_truncator_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned glyph_cols(logic [20:0] cp);
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) return 0;
    if ((cp >= 21'h1100 && cp <= 21'h115F) || (cp >= 21'h2E80 && cp <= 21'h303E) ||
        (cp >= 21'h3041 && cp <= 21'h33FF) || (cp >= 21'h3400 && cp <= 21'h4DBF) ||
        (cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'hA000 && cp <= 21'hA4CF) ||
        (cp >= 21'hAC00 && cp <= 21'hD7A3) || (cp >= 21'hF900 && cp <= 21'hFAFF) ||
        (cp >= 21'hFE30 && cp <= 21'hFE4F) || (cp >= 21'hFF00 && cp <= 21'hFF60) ||
        (cp >= 21'hFFE0 && cp <= 21'hFFE6) || (cp >= 21'h1F300 && cp <= 21'h1F9FF) ||
        (cp >= 21'h20000 && cp <= 21'h2FFFD)) return 2;
    return 1;
  endfunction

  function automatic void add_glyph(logic [20:0] cp);
    logic [17:0] nxt;
    nxt = {1'b0, col_sum} + 18'(glyph_cols(cp));
    if (!cut_seen && nxt >= {2'b00, col_limit}) begin
      cut_seen = 1'b1;
      cut_at = glyph_start;
    end
    col_sum = (nxt > {1'b0, WIDTH_CAP}) ? WIDTH_CAP : nxt[16:0];
  endfunction

  function automatic void scan_byte(logic [7:0] b, logic last);
    out_item_t res;
    if (scan_pos < POS_CAP) begin
      if (!scan_halted) begin
        if (cont_left == 0) begin
          glyph_start = scan_pos;
          if (b[7] == 1'b0) begin
            add_glyph({13'd0, b});
          end else if (b[7:5] == 3'b110) begin
            cp_acc = {16'd0, b[4:0]};
            cont_left = 3'd1;
          end else if (b[7:4] == 4'b1110) begin
            cp_acc = {17'd0, b[3:0]};
            cont_left = 3'd2;
          end else if (b[7:3] == 5'b11110) begin
            cp_acc = {18'd0, b[2:0]};
            cont_left = 3'd3;
          end else begin
            scan_halted = 1'b1;
          end
        end else begin
          cp_acc = {cp_acc[14:0], b[5:0]};
          cont_left = cont_left - 3'd1;
          if (cont_left == 0) add_glyph(cp_acc);
        end
      end
      scan_pos = scan_pos + 16'd1;
    end else begin
      scan_halted = 1'b1;
    end
    if (last) begin
      if (col_limit == 0) begin
        res.keep_bytes = '0;
        res.add_ellipsis = 1'b0;
      end else if (col_sum <= {1'b0, col_limit} || !cut_seen) begin
        res.keep_bytes = scan_pos;
        res.add_ellipsis = 1'b0;
      end else begin
        res.keep_bytes = cut_at;
        res.add_ellipsis = 1'b1;
      end
      res.total_width = col_sum;
      pending_results.push_back(res);
      scan_pos = '0;
      cp_acc = '0;
      cont_left = '0;
      glyph_start = '0;
      col_sum = '0;
      scan_halted = 1'b0;
      cut_seen = 1'b0;
      cut_at = '0;
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", out_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.keep_bytes !== want.keep_bytes)
          report_mismatch("keep_bytes", out_data.keep_bytes, want.keep_bytes);
        if (out_data.add_ellipsis !== want.add_ellipsis)
          report_mismatch("add_ellipsis", out_data.add_ellipsis, want.add_ellipsis);
        if (out_data.total_width !== want.total_width)
          report_mismatch("total_width", out_data.total_width, want.total_width);
      end
    end
  end

  // result-side stall bursts
  always @(posedge clk) begin
    if (rst || !stall_en) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!out_stall && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** utf8_display_width_truncator_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, is_last: last};
    do @(posedge clk); while (in_stall);
    scan_byte(b, last);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++)
      push_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_col_limit(logic [15:0] lim);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    col_limit = lim;
  endtask

  function automatic void append_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      str_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      str_bytes.push_back({3'b110, cp[10:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      str_bytes.push_back({4'b1110, cp[15:12]});
      str_bytes.push_back({2'b10, cp[11:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      str_bytes.push_back({5'b11110, cp[20:18]});
      str_bytes.push_back({2'b10, cp[17:12]});
      str_bytes.push_back({2'b10, cp[11:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [20:0] near_range_limit();
    logic [20:0] lo;
    logic [20:0] hi;
    case ($urandom_range(0, 14))
      0:  begin lo = 21'h0;     hi = 21'h1F;    end
      1:  begin lo = 21'h7F;    hi = 21'h9F;    end
      2:  begin lo = 21'h1100;  hi = 21'h115F;  end
      3:  begin lo = 21'h2E80;  hi = 21'h303E;  end
      4:  begin lo = 21'h3041;  hi = 21'h33FF;  end
      5:  begin lo = 21'h3400;  hi = 21'h4DBF;  end
      6:  begin lo = 21'h4E00;  hi = 21'h9FFF;  end
      7:  begin lo = 21'hA000;  hi = 21'hA4CF;  end
      8:  begin lo = 21'hAC00;  hi = 21'hD7A3;  end
      9:  begin lo = 21'hF900;  hi = 21'hFAFF;  end
      10: begin lo = 21'hFE30;  hi = 21'hFE4F;  end
      11: begin lo = 21'hFF00;  hi = 21'hFF60;  end
      12: begin lo = 21'hFFE0;  hi = 21'hFFE6;  end
      13: begin lo = 21'h1F300; hi = 21'h1F9FF; end
      default: begin lo = 21'h20000; hi = 21'h2FFFD; end
    endcase
    case ($urandom_range(0, 4))
      0: return lo - 21'd1;
      1: return lo;
      2: return hi;
      3: return hi + 21'd1;
      default: return 21'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [7:0] invalid_lead();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h80, 8'hBF));
    return 8'($urandom_range(8'hF8, 8'hFF));
  endfunction

  function automatic void append_char();
    char_kind_t kind;
    int n;
    n = $urandom_range(0, 9);
    kind = (n < 4) ? CH_RANGE_EDGE : (n < 7) ? CH_ASCII : CH_RAW;
    case (kind)
      CH_RANGE_EDGE: append_cp(near_range_limit());
      CH_ASCII: str_bytes.push_back(8'($urandom_range(0, 8'h7F)));
      default: begin
        // lead of a random class, continuation bytes with any top bits
        n = $urandom_range(1, 4);
        case (n)
          1: str_bytes.push_back({1'b0, 7'($urandom)});
          2: str_bytes.push_back({3'b110, 5'($urandom)});
          3: str_bytes.push_back({4'b1110, 4'($urandom)});
          default: str_bytes.push_back({5'b11110, 3'($urandom)});
        endcase
        repeat (n - 1) str_bytes.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  task automatic build_random_string();
    int n_chars;
    int broken;
    str_bytes.delete();
    n_chars = $urandom_range(1, 8);
    broken = $urandom_range(0, 9);
    for (int i = 0; i < n_chars; i++) begin
      if (broken == 0 && i == n_chars / 2) str_bytes.push_back(invalid_lead());
      append_char();
    end
    if (broken == 1) begin
      // multibyte character cut off by the end of the string
      str_bytes.push_back({5'b11110, 3'($urandom)});
      repeat ($urandom_range(0, 2)) str_bytes.push_back({2'b10, 6'($urandom)});
    end
  endtask

  task automatic test_lead_classes();
    str_bytes = '{8'h00, 8'h41, 8'h7F, 8'hC2, 8'hA9, 8'hE4, 8'hB8, 8'h80,
                  8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'h41};
    send_string();
  endtask

  task automatic test_cut_off_tail();
    str_bytes = '{8'h41, 8'hE4, 8'hB8};
    send_string();
  endtask

  task automatic test_zero_limit();
    set_col_limit(16'd0);
    str_bytes = '{8'h41, 8'h42};
    send_string();
  endtask

  task automatic test_truncation();
    set_col_limit(16'd3);
    str_bytes = '{8'h41, 8'hE4, 8'hB8, 8'h80, 8'h41};
    send_string();
    // width lands exactly on the limit: whole string kept
    str_bytes = '{8'h41, 8'h41, 8'h41};
    send_string();
  endtask

  task automatic test_random_phase(logic [15:0] lim, int n_bytes, bit quiet);
    int sent;
    set_col_limit(lim);
    idle_en = !quiet;
    stall_en = !quiet;
    sent = 0;
    while (sent < n_bytes) begin
      build_random_string();
      sent += str_bytes.size();
      send_string();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_lead_classes();
    test_cut_off_tail();
    test_zero_limit();
    test_truncation();
    test_random_phase(16'hFFFF, 65, 1'b0);
    test_random_phase(16'd0, 55, 1'b0);
    test_random_phase(16'd1, 55, 1'b0);
    test_random_phase(16'($urandom_range(2, 6)), 75, 1'b0);
    test_random_phase(16'($urandom_range(7, 40)), 75, 1'b0);
    test_random_phase(16'($urandom_range(2, 20)), 75, 1'b1);
    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("** utf8_display_width_truncator_core: PASSED **");
    end else begin
      $display("** utf8_display_width_truncator_core: FAILED **");
    end
    $finish;
  end

endmodule
